>>> hw/rtl/oal_pkg.sv
`default_nettype none
package oal_pkg;

	localparam int DEPTH   = 16;
	localparam int WORD_W  = 32;
	localparam int CNT_W   = 5;
	localparam int KIND_W  = 3;
	localparam int STAT_W  = 2;
	localparam int CAP_W   = 5;
	localparam int PADDR_W = 3;
	localparam int PDATA_W = 32;

	localparam logic [CAP_W-1:0] CAP_RESET = CAP_W'(16);
	localparam logic [PADDR_W-3:0] REG_CAPACITY = '0;
	localparam logic signed [WORD_W-1:0] ERR_WORD = '1;

	// request kinds
	localparam logic [KIND_W-1:0] KIND_INS_POS   = 3'd0;
	localparam logic [KIND_W-1:0] KIND_INS_END   = 3'd1;
	localparam logic [KIND_W-1:0] KIND_INS_FRONT = 3'd2;
	localparam logic [KIND_W-1:0] KIND_REM_POS   = 3'd3;
	localparam logic [KIND_W-1:0] KIND_REM_FRONT = 3'd4;
	localparam logic [KIND_W-1:0] KIND_REM_END   = 3'd5;
	localparam logic [KIND_W-1:0] KIND_SEARCH    = 3'd6;

	localparam logic [STAT_W-1:0] ST_OK     = 2'd0;
	localparam logic [STAT_W-1:0] ST_FULL   = 2'd1;
	localparam logic [STAT_W-1:0] ST_EMPTY  = 2'd2;
	localparam logic [STAT_W-1:0] ST_BADPOS = 2'd3;

	typedef enum logic [1:0] {
		CELL_HOLD,
		CELL_INSERT,
		CELL_REMOVE
	} cell_op_t;

	typedef struct packed {
		logic [KIND_W-1:0]        kind;
		logic signed [WORD_W-1:0] item_value;
		logic [CNT_W-1:0]         position;
	} req_t;

	typedef struct packed {
		logic signed [WORD_W-1:0] removed_value;
		logic                     found;
		logic [STAT_W-1:0]        status;
		logic [CNT_W-1:0]         entry_count;
	} rsp_t;

	// broadcast to every cell of the chain
	typedef struct packed {
		cell_op_t                 op;
		logic [CNT_W-1:0]         pos;
		logic [CNT_W-1:0]         count;
		logic signed [WORD_W-1:0] word;
	} cell_ctrl_t;

endpackage
`default_nettype wire

>>> hw/rtl/oal_cell.sv
`default_nettype none
module oal_cell (
	input  wire logic                             clk,
	input  wire oal_pkg::cell_ctrl_t              ctrl,
	input  wire logic [oal_pkg::CNT_W-1:0]        idx,
	input  wire logic signed [oal_pkg::WORD_W-1:0] left,
	input  wire logic signed [oal_pkg::WORD_W-1:0] right,
	output logic signed [oal_pkg::WORD_W-1:0]      value,
	output logic signed [oal_pkg::WORD_W-1:0]      sel_value,
	output logic                                   match
);
	import oal_pkg::*;

	logic signed [WORD_W-1:0] value_q;

	always_ff @(posedge clk) begin
		case (ctrl.op)
			CELL_INSERT: begin
				if (idx == ctrl.pos) begin
					value_q <= ctrl.word;
				end else if (idx > ctrl.pos) begin
					value_q <= left;
				end
			end
			CELL_REMOVE: begin
				if (idx >= ctrl.pos) begin
					value_q <= right;
				end
			end
			default: begin
				value_q <= value_q;
			end
		endcase
	end

	assign value     = value_q;
	// only the addressed cell puts its word on the or-bus
	assign sel_value = (idx == ctrl.pos) ? value_q : '0;
	assign match     = (idx < ctrl.count) && (value_q == ctrl.word);

endmodule
`default_nettype wire

>>> hw/rtl/ordered_array_list_unit.sv
`default_nettype none
// latency: a request accepted at one edge has its result, marked by done, in the next cycle
// throughput: one request per cycle, busy stays low; every cell of the chain shifts,
//   loads or compares in the cycle of the request
// reset: count and done clear, capacity returns to 16, list words stay undefined until written
// the receiver cannot stall: each result is shown for exactly one cycle
module ordered_array_list_unit (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          start,
	output logic                               busy,
	input  wire oal_pkg::req_t                 request,
	output logic                               done,
	output oal_pkg::rsp_t                      result,
	input  wire logic                          psel,
	input  wire logic                          penable,
	input  wire logic                          pwrite,
	input  wire logic [oal_pkg::PADDR_W-1:0]   paddr,
	input  wire logic [oal_pkg::PDATA_W-1:0]   pwdata,
	output logic [oal_pkg::PDATA_W-1:0]        prdata,
	output logic                               pready
);
	import oal_pkg::*;

	logic [CAP_W-1:0]  cap_q;
	logic [CNT_W-1:0]  count_q;
	logic              done_q;
	rsp_t              rsp_q;

	cell_ctrl_t        ctrl;
	logic              accept;
	logic              is_ins;
	logic              is_rem;
	logic              is_search;
	logic [CNT_W-1:0]  pos;
	logic [CNT_W-1:0]  eff_cap;
	logic              full;
	logic [STAT_W-1:0] status;
	logic [CNT_W-1:0]  count_next;
	logic signed [WORD_W-1:0] removed;
	logic signed [WORD_W-1:0] sel_or;
	logic              found_any;

	logic signed [WORD_W-1:0] cell_value [DEPTH];
	logic signed [WORD_W-1:0] cell_sel   [DEPTH];
	logic [DEPTH-1:0]         cell_match;

	assign busy   = 1'b0;
	assign pready = 1'b1;
	assign accept = start && !busy;

	// configuration port
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cap_q <= CAP_RESET;
		end else if (psel && penable && pwrite && pready
				&& paddr[PADDR_W-1:2] == REG_CAPACITY) begin
			cap_q <= pwdata[CAP_W-1:0];
		end
	end

	assign prdata = (paddr[PADDR_W-1:2] == REG_CAPACITY)
		? {{(PDATA_W-CAP_W){1'b0}}, cap_q} : '0;

	// request decode
	assign eff_cap = (cap_q < CAP_W'(DEPTH)) ? cap_q : CAP_W'(DEPTH);
	assign full    = (count_q >= eff_cap) || (count_q >= CNT_W'(DEPTH));

	always_comb begin
		is_ins    = 1'b0;
		is_rem    = 1'b0;
		is_search = 1'b0;
		pos       = '0;
		case (request.kind)
			KIND_INS_POS: begin
				is_ins = 1'b1;
				pos    = request.position;
			end
			KIND_INS_END: begin
				is_ins = 1'b1;
				pos    = count_q;
			end
			KIND_INS_FRONT: begin
				is_ins = 1'b1;
			end
			KIND_REM_POS: begin
				is_rem = 1'b1;
				pos    = request.position;
			end
			KIND_REM_FRONT: begin
				is_rem = 1'b1;
			end
			KIND_REM_END: begin
				is_rem = 1'b1;
				pos    = (count_q == '0) ? '0 : count_q - CNT_W'(1);
			end
			KIND_SEARCH: begin
				is_search = 1'b1;
			end
			default: begin
				is_ins = 1'b0;
			end
		endcase
	end

	always_comb begin
		status = ST_OK;
		if (is_ins) begin
			if (full) begin
				status = ST_FULL;
			end else if (pos > count_q) begin
				status = ST_BADPOS;
			end
		end else if (is_rem) begin
			if (count_q == '0) begin
				status = ST_EMPTY;
			end else if (pos >= count_q) begin
				status = ST_BADPOS;
			end
		end
	end

	always_comb begin
		ctrl.op    = CELL_HOLD;
		ctrl.pos   = pos;
		ctrl.count = count_q;
		ctrl.word  = request.item_value;
		count_next = count_q;
		if (accept && status == ST_OK) begin
			if (is_ins) begin
				ctrl.op    = CELL_INSERT;
				count_next = count_q + CNT_W'(1);
			end else if (is_rem) begin
				ctrl.op    = CELL_REMOVE;
				count_next = count_q - CNT_W'(1);
			end
		end
	end

	// cell chain
	for (genvar i = 0; i < DEPTH; i++) begin : g_cell
		logic signed [WORD_W-1:0] left_w;
		logic signed [WORD_W-1:0] right_w;
		if (i == 0) begin : g_first
			assign left_w = '0;
		end else begin : g_left
			assign left_w = cell_value[i-1];
		end
		if (i == DEPTH - 1) begin : g_last
			assign right_w = '0;
		end else begin : g_right
			assign right_w = cell_value[i+1];
		end
		oal_cell u_cell (
			.clk       (clk),
			.ctrl      (ctrl),
			.idx       (CNT_W'(i)),
			.left      (left_w),
			.right     (right_w),
			.value     (cell_value[i]),
			.sel_value (cell_sel[i]),
			.match     (cell_match[i])
		);
	end

	always_comb begin
		sel_or = '0;
		for (int k = 0; k < DEPTH; k++) begin
			sel_or = sel_or | cell_sel[k];
		end
	end

	assign found_any = |cell_match;
	assign removed   = (is_rem && status == ST_OK) ? sel_or : ERR_WORD;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
			done_q  <= 1'b0;
		end else begin
			count_q <= count_next;
			done_q  <= accept;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			rsp_q.removed_value <= removed;
			rsp_q.found         <= is_search && found_any;
			rsp_q.status        <= status;
			rsp_q.entry_count   <= count_next;
		end
	end

	assign done   = done_q;
	assign result = rsp_q;

	// the list never grows past its storage
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CNT_W'(DEPTH))
		else $error("entry count above depth");

	// the word count moves only on an accepted request
	a_count_idle: assert property (@(posedge clk) disable iff (!arst_n)
		!accept |=> $stable(count_q))
		else $error("entry count changed without a request");

	// a reported count matches the list state
	a_count_report: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> result.entry_count == count_q)
		else $error("reported count differs from list state");

	// a failing request gives the error word
	a_err_word: assert property (@(posedge clk) disable iff (!arst_n)
		done && result.status != ST_OK |-> result.removed_value == ERR_WORD)
		else $error("error result without error word");

endmodule
`default_nettype wire

>>> verif/oal_list_checker.sv
`timescale 1ns / 100ps
module oal_list_checker (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        start,
	input  logic                        busy,
	input  oal_pkg::req_t               request,
	input  logic                        done,
	input  oal_pkg::rsp_t               result,
	input  logic                        psel,
	input  logic                        penable,
	input  logic                        pwrite,
	input  logic [oal_pkg::PADDR_W-1:0] paddr,
	input  logic [oal_pkg::PDATA_W-1:0] pwdata,
	input  logic [oal_pkg::PDATA_W-1:0] prdata,
	input  logic                        pready,
	output int                          mismatch_count,
	output int                          results_owed,
	output int                          list_length
);
	import oal_pkg::*;

	logic signed [WORD_W-1:0] list_words [DEPTH];
	int                       n_entries;
	logic [CAP_W-1:0]         capacity;
	rsp_t                     owed_results [$];

	// applies one request to the shadow list and returns the word it should produce
	function automatic rsp_t serve_request(req_t rq);
		rsp_t rs;
		int   limit;
		int   at;
		int   i;
		rs.removed_value = ERR_WORD;
		rs.found         = 1'b0;
		rs.status        = ST_OK;
		limit = (capacity < DEPTH) ? int'(capacity) : DEPTH;
		case (rq.kind)
			KIND_INS_POS, KIND_INS_END, KIND_INS_FRONT: begin
				if (rq.kind == KIND_INS_POS)
					at = int'(rq.position);
				else if (rq.kind == KIND_INS_END)
					at = n_entries;
				else
					at = 0;
				// full is checked ahead of the position
				if (n_entries >= limit || n_entries >= DEPTH) begin
					rs.status = ST_FULL;
				end else if (at > n_entries) begin
					rs.status = ST_BADPOS;
				end else begin
					for (i = n_entries; i > at; i--)
						list_words[i] = list_words[i-1];
					list_words[at] = rq.item_value;
					n_entries++;
				end
			end
			KIND_REM_POS, KIND_REM_FRONT, KIND_REM_END: begin
				if (rq.kind == KIND_REM_POS)
					at = int'(rq.position);
				else if (rq.kind == KIND_REM_FRONT)
					at = 0;
				else
					at = (n_entries == 0) ? 0 : n_entries - 1;
				if (n_entries == 0) begin
					rs.status = ST_EMPTY;
				end else if (at >= n_entries) begin
					rs.status = ST_BADPOS;
				end else begin
					rs.removed_value = list_words[at];
					n_entries--;
					for (i = at; i < n_entries; i++)
						list_words[i] = list_words[i+1];
				end
			end
			KIND_SEARCH: begin
				for (i = 0; i < n_entries; i++)
					if (list_words[i] == rq.item_value)
						rs.found = 1'b1;
			end
			default: begin
			end
		endcase
		rs.entry_count = CNT_W'(n_entries);
		return rs;
	endfunction

	function automatic void check_field(string name, logic [31:0] want, logic [31:0] got);
		if (got !== want) begin
			$display("%0t: %s mismatch, expected %h, actual %h", $time, name, want, got);
			mismatch_count++;
		end
	endfunction

	always @(posedge clk or negedge arst_n) begin
		rsp_t want;
		if (!arst_n) begin
			n_entries      = 0;
			capacity       = CAP_RESET;
			mismatch_count = 0;
			owed_results.delete();
		end else begin
			if (start && !busy)
				owed_results.push_back(serve_request(request));
			if (done) begin
				if (owed_results.size() == 0) begin
					$display("%0t: result word with nothing outstanding, expected none, actual %p",
						$time, result);
					mismatch_count++;
				end else begin
					want = owed_results.pop_front();
					check_field("removed_value", want.removed_value, result.removed_value);
					check_field("found", 32'(want.found), 32'(result.found));
					check_field("status", 32'(want.status), 32'(result.status));
					check_field("entry_count", 32'(want.entry_count), 32'(result.entry_count));
				end
			end
			if (psel && penable && pready && paddr[PADDR_W-1:2] == REG_CAPACITY) begin
				if (pwrite)
					capacity = pwdata[CAP_W-1:0];
				else
					check_field("capacity readback", PDATA_W'(capacity), prdata);
			end
		end
		results_owed = owed_results.size();
		list_length  = n_entries;
	end

endmodule

>>> verif/tb.sv
`timescale 1ns / 100ps
module tb;
	import oal_pkg::*;

	localparam logic [KIND_W-1:0] KIND_UNUSED = 3'd7;
	localparam int STALL_LIMIT = 1000;
	localparam int N_PHASES    = 10;
	localparam int PHASE_ITEMS = 60;

	logic               clk     = 1'b0;
	logic               arst_n  = 1'b0;
	logic               start   = 1'b0;
	req_t               request = '0;
	logic               psel    = 1'b0;
	logic               penable = 1'b0;
	logic               pwrite  = 1'b0;
	logic [PADDR_W-1:0] paddr   = '0;
	logic [PDATA_W-1:0] pwdata  = '0;
	logic               busy;
	logic               done;
	rsp_t               result;
	logic [PDATA_W-1:0] prdata;
	logic               pready;

	int mismatch_count;
	int results_owed;
	int list_length;
	int quiet_cycles = 0;
	bit steady       = 1'b0;

	logic signed [WORD_W-1:0] recent_values [$];

	ordered_array_list_unit dut (.*);
	oal_list_checker chk (.*);

	always #5 clk = ~clk;

	// watchdog: cycles with no word moving on any channel
	always @(posedge clk) begin
		if ((start && !busy) || done || (psel && penable)) begin
			quiet_cycles <= 0;
		end else if (quiet_cycles >= STALL_LIMIT) begin
			$display("FAIL ordered_array_list_unit");
			$finish;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
		end
	end

	task automatic submit(logic [KIND_W-1:0] k, logic signed [WORD_W-1:0] v,
			logic [CNT_W-1:0] p);
		req_t rq;
		rq.kind       = k;
		rq.item_value = v;
		rq.position   = p;
		if (!steady && $urandom_range(0, 99) < 15) begin
			start <= 1'b0;
			@(posedge clk);
		end
		start   <= 1'b1;
		request <= rq;
		do @(posedge clk); while (busy);
		if (k == KIND_INS_POS || k == KIND_INS_END || k == KIND_INS_FRONT) begin
			recent_values.push_back(v);
			if (recent_values.size() > 16)
				void'(recent_values.pop_front());
		end
	endtask

	// write the capacity once the list is quiet, then read it back
	task automatic set_capacity(logic [CAP_W-1:0] cap);
		start <= 1'b0;
		do @(posedge clk); while (results_owed != 0);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= {REG_CAPACITY, 2'b00};
		pwdata  <= PDATA_W'(cap);
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		penable <= 1'b0;
		pwrite  <= 1'b0;
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		psel    <= 1'b0;
		penable <= 1'b0;
	endtask

	initial begin : stimulus
		int                       roll;
		int                       insert_pct;
		int                       remove_pct;
		int                       phase;
		int                       n;
		logic [KIND_W-1:0]        k;
		logic signed [WORD_W-1:0] v;
		logic [CNT_W-1:0]         p;
		logic [CAP_W-1:0]         phase_cap [N_PHASES];

		phase_cap = '{5'd16, 5'd2, 5'd0, 5'd31, 5'd1, 5'd5, 5'd16, 5'd3, 5'd16, 5'd31};
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// empty list
		submit(KIND_REM_FRONT, 32'sd7, 5'd0);
		submit(KIND_REM_END, 32'sd7, 5'd0);
		submit(KIND_REM_POS, 32'sd7, 5'd0);
		submit(KIND_SEARCH, 32'sd0, 5'd0);
		submit(KIND_INS_POS, 32'sd9, 5'd1);
		// build a list with the corner words
		submit(KIND_INS_POS, 32'sh7fffffff, 5'd0);
		submit(KIND_INS_END, 32'sh80000000, 5'd0);
		submit(KIND_INS_FRONT, -32'sd1, 5'd0);
		submit(KIND_INS_POS, 32'sd0, 5'd3);
		submit(KIND_INS_POS, 32'sd5, 5'd31);
		submit(KIND_INS_POS, 32'sh5a5a5a5a, 5'd2);
		submit(KIND_SEARCH, 32'sh80000000, 5'd0);
		submit(KIND_SEARCH, 32'sh12345678, 5'd0);
		submit(KIND_UNUSED, 32'sd3, 5'd1);
		submit(KIND_REM_POS, 32'sd0, 5'd31);
		submit(KIND_REM_POS, 32'sd0, 5'd5);
		submit(KIND_REM_POS, 32'sd0, 5'd2);
		submit(KIND_REM_END, 32'sd0, 5'd0);
		submit(KIND_REM_FRONT, 32'sd0, 5'd0);
		// capacity under the count: inserts fail as full before the position check
		set_capacity(5'd1);
		submit(KIND_INS_END, 32'sd11, 5'd0);
		submit(KIND_INS_POS, 32'sd12, 5'd31);
		submit(KIND_SEARCH, -32'sd1, 5'd0);
		submit(KIND_REM_POS, 32'sd0, 5'd1);
		set_capacity(5'd0);
		submit(KIND_INS_FRONT, 32'sd13, 5'd0);
		submit(KIND_REM_FRONT, 32'sd0, 5'd0);
		submit(KIND_REM_END, 32'sd0, 5'd0);

		for (phase = 0; phase < N_PHASES; phase++) begin
			set_capacity(phase == 7 ? 5'($urandom_range(0, 31)) : phase_cap[phase]);
			steady     = (phase == 5 || phase == 6);
			insert_pct = (phase % 2 == 0) ? 65 : 25;
			remove_pct = (phase % 2 == 0) ? 20 : 55;
			for (n = 0; n < PHASE_ITEMS; n++) begin
				roll = $urandom_range(0, 99);
				if (roll < insert_pct) begin
					roll = $urandom_range(0, 3);
					k = (roll < 2) ? KIND_INS_POS : (roll == 2) ? KIND_INS_END : KIND_INS_FRONT;
				end else if (roll < insert_pct + remove_pct) begin
					roll = $urandom_range(0, 3);
					k = (roll < 2) ? KIND_REM_POS : (roll == 2) ? KIND_REM_FRONT : KIND_REM_END;
				end else if (roll < 97) begin
					k = KIND_SEARCH;
				end else begin
					k = KIND_UNUSED;
				end

				// mostly in-range positions, now and then anything the field holds
				if ($urandom_range(0, 99) < 85)
					p = CNT_W'($urandom_range(0, (k == KIND_INS_POS) ? list_length
						: (list_length > 0 ? list_length - 1 : 0)));
				else
					p = CNT_W'($urandom_range(0, 31));

				roll = $urandom_range(0, 99);
				if (recent_values.size() > 0 && (roll < 15 || (k == KIND_SEARCH && roll < 55)))
					v = recent_values[$urandom_range(0, recent_values.size() - 1)];
				else if (roll < 85)
					v = $urandom();
				else
					case ($urandom_range(0, 3))
						0: v = 32'sd0;
						1: v = -32'sd1;
						2: v = 32'sh80000000;
						default: v = 32'sh7fffffff;
					endcase
				submit(k, v, p);
			end
		end

		start <= 1'b0;
		do @(posedge clk); while (results_owed != 0);
		repeat (4) @(posedge clk);
		if (mismatch_count == 0 && results_owed == 0)
			$display("PASS ordered_array_list_unit");
		else
			$display("FAIL ordered_array_list_unit");
		$finish;
	end

endmodule
